@@ rtl/bsm_pkg.sv @@
// Shared types and constants for the breakpoint and step matcher.
// Used by bsm_front, bsm_back and the top level.
`default_nettype none
package bsm_pkg;
  localparam int unsigned NumSlotsDef = 16;
  localparam int unsigned CmdQDepth = 2;

  localparam logic [2:0] KindAdd     = 3'd0;
  localparam logic [2:0] KindRemove  = 3'd1;
  localparam logic [2:0] KindEnable  = 3'd2;
  localparam logic [2:0] KindCond    = 3'd3;
  localparam logic [2:0] KindLog     = 3'd4;
  localparam logic [2:0] KindCheck   = 3'd5;
  localparam logic [2:0] KindResume  = 3'd6;

  localparam logic [2:0] StepCont  = 3'd0;
  localparam logic [2:0] StepInto  = 3'd1;
  localparam logic [2:0] StepOver  = 3'd2;
  localparam logic [2:0] StepOut   = 3'd3;
  localparam logic [2:0] StepPause = 3'd4;

  localparam logic [0:0] RegDebugEn = 1'd0;
  localparam logic [0:0] RegCondEv  = 1'd1;

  // classified command handed from front to back
  typedef struct packed {
    logic [2:0]  kind;
    logic        step_hit;   // step rule pauses this check
    logic [31:0] script_id;
    logic [31:0] line_number;
    logic [31:0] bp_id;
    logic        flag;
    logic [15:0] cmask;
  } cmd_t;

  typedef struct packed {
    logic        pause;
    logic        ok;
    logic [31:0] assigned_id;
    logic [15:0] log_mask;
  } res_t;
endpackage
`default_nettype wire

@@ rtl/breakpoint_and_step_matcher.sv @@
// Top level of the breakpoint and step matcher: APB config, front and back.
// Depends on bsm_pkg, bsm_front, bsm_back.
`default_nettype none
// Commands pass through a two-entry queue to the back end, which handles
// one at a time. A table command's result goes from the queue entry through
// the command register and the StDone state into the result register; an
// instruction check that scans goes on through StScan, one slot per cycle
// over the table, stopping at a pausing hit. A result waits in an output
// register until popped, and the back end takes no new command while it waits.
module breakpoint_and_step_matcher #(
  parameter int unsigned NUM_SLOTS = bsm_pkg::NumSlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  kind_i,
  input  logic [31:0] script_id_i,
  input  logic [31:0] line_number_i,
  input  logic [15:0] call_depth_i,
  input  logic [31:0] bp_id_i,
  input  logic        flag_i,
  input  logic [15:0] condition_pass_mask_i,
  input  logic [2:0]  action_i,
  output logic        empty,
  input  logic        pop,
  output logic        pause_o,
  output logic        ok_o,
  output logic [31:0] assigned_id_o,
  output logic [15:0] log_mask_o,
  output logic [4:0]  active_count_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bsm_pkg::*;

  logic dbg_q, cev_q, cmd_valid, cmd_take;
  cmd_t cmd;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbg_q <= 1'b0;
      cev_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      if (paddr[2] == RegDebugEn) dbg_q <= pwdata[0];
      else cev_q <= pwdata[0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) prdata[0] = (paddr[2] == RegCondEv) ? cev_q : dbg_q;
  end

  bsm_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .kind_i, .script_id_i,
    .line_number_i, .call_depth_i, .bp_id_i, .flag_i, .condition_pass_mask_i,
    .action_i, .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_take_i(cmd_take)
  );

  bsm_back #(.NumSlots(NUM_SLOTS)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_take_o(cmd_take),
    .debug_en_i(dbg_q), .cond_ev_i(cev_q), .empty_o(empty), .pop_i(pop),
    .pause_o, .ok_o, .assigned_id_o, .log_mask_o, .active_count_o
  );
endmodule
`default_nettype wire

@@ rtl/bsm_front.sv @@
// Front end: takes input transfers, applies the step rules, queues commands.
// Depends on bsm_pkg.
`default_nettype none
module bsm_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  logic [2:0]     kind_i,
  input  logic [31:0]    script_id_i,
  input  logic [31:0]    line_number_i,
  input  logic [15:0]    call_depth_i,
  input  logic [31:0]    bp_id_i,
  input  logic           flag_i,
  input  logic [15:0]    condition_pass_mask_i,
  input  logic [2:0]     action_i,
  output logic           cmd_valid_o,
  output bsm_pkg::cmd_t  cmd_o,
  input  logic           cmd_take_i
);
  import bsm_pkg::*;

  logic [2:0]  step_mode_q, step_mode_d;
  logic [15:0] step_depth_q, step_depth_d;
  cmd_t        q_mem [CmdQDepth];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        acc, step_hit;
  cmd_t        new_cmd;

  assign full_o = (cnt_q == 2'(CmdQDepth));
  assign acc = push_i && !full_o;

  always_comb begin
    step_hit = (step_mode_q == StepInto) ||
               (step_mode_q == StepOver && call_depth_i <= step_depth_q) ||
               (step_mode_q == StepOut && call_depth_i < step_depth_q);
    new_cmd.kind = kind_i;
    new_cmd.step_hit = step_hit;
    new_cmd.script_id = script_id_i;
    new_cmd.line_number = line_number_i;
    new_cmd.bp_id = bp_id_i;
    new_cmd.flag = flag_i;
    new_cmd.cmask = condition_pass_mask_i;
    step_mode_d = step_mode_q;
    step_depth_d = step_depth_q;
    if (acc && kind_i == KindResume) begin
      step_mode_d = (action_i <= StepPause) ? action_i : StepCont;
      step_depth_d = call_depth_i;
    end
  end

  // step state is applied in order since both live here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_mode_q <= StepCont;
      step_depth_q <= '0;
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      step_mode_q <= step_mode_d;
      step_depth_q <= step_depth_d;
      if (acc) wr_q <= ~wr_q;
      if (cmd_take_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(acc) - 2'(cmd_take_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) q_mem[wr_q] <= new_cmd;
  end

  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o = q_mem[rd_q];

  a_take_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take_i |-> cmd_valid_o) else $error("take from empty queue");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(CmdQDepth)) else $error("queue overflow");
  a_resume: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && kind_i == KindResume) |=> step_depth_q == $past(call_depth_i))
    else $error("step depth not recorded");
endmodule
`default_nettype wire

@@ rtl/bsm_back.sv @@
// Back end: slot table, command execution and slot scan, result register.
// Depends on bsm_pkg.
`default_nettype none
module bsm_back #(
  parameter int unsigned NumSlots = bsm_pkg::NumSlotsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  bsm_pkg::cmd_t  cmd_i,
  output logic           cmd_take_o,
  input  logic           debug_en_i,
  input  logic           cond_ev_i,
  output logic           empty_o,
  input  logic           pop_i,
  output logic           pause_o,
  output logic           ok_o,
  output logic [31:0]    assigned_id_o,
  output logic [15:0]    log_mask_o,
  output logic [4:0]     active_count_o
);
  import bsm_pkg::*;

  localparam int unsigned SW = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int unsigned CW = $clog2(NumSlots + 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [NumSlots-1:0] valid_q, en_q, cond_q, logp_q, msg_q;
  logic [31:0] ident_q [NumSlots];
  logic [31:0] script_q [NumSlots];
  logic [31:0] line_q [NumSlots];
  logic [31:0] hits_q [NumSlots];
  logic [31:0] next_id_q;
  logic [CW-1:0] count_q;
  logic [1:0]  st_q;
  logic [SW-1:0] idx_q;
  cmd_t        cur_q;
  res_t        res_q;
  logic        res_full_q;

  logic [SW-1:0] free_idx, id_idx;
  logic          free_any, id_any;

  always_comb begin
    free_idx = '0; free_any = 1'b0;
    id_idx = '0; id_any = 1'b0;
    for (int s = NumSlots - 1; s >= 0; s--) begin
      if (!valid_q[s]) begin free_idx = SW'(s); free_any = 1'b1; end
      if (valid_q[s] && ident_q[s] == cur_q.bp_id) begin
        id_idx = SW'(s); id_any = 1'b1;
      end
    end
  end

  logic start, last, match, pass, is_log, scan_go;
  res_t done_res;
  assign start = (st_q == StIdle) && cmd_valid_i && !res_full_q;
  assign cmd_take_o = start;
  assign last = (32'(idx_q) == NumSlots - 1);
  assign match = valid_q[idx_q] && en_q[idx_q] && script_q[idx_q] == cur_q.script_id &&
                 line_q[idx_q] == cur_q.line_number;
  assign pass = !(cond_q[idx_q] && cond_ev_i) ||
                (32'(idx_q) < 16 && cur_q.cmask[4'(idx_q)]);
  assign is_log = logp_q[idx_q];
  assign scan_go = (cur_q.kind == KindCheck) && debug_en_i && !cur_q.step_hit;

  // result of a command that needs no scan, and the starting result of a scan
  always_comb begin
    done_res = '0;
    priority case (cur_q.kind)
      KindAdd: begin
        done_res.ok = free_any;
        done_res.assigned_id = free_any ? next_id_q : 32'd0;
      end
      KindRemove, KindEnable, KindCond, KindLog: done_res.ok = id_any;
      KindCheck: done_res.pause = debug_en_i && cur_q.step_hit;
      KindResume: done_res.ok = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      next_id_q <= 32'd1;
      count_q <= '0;
      st_q <= StIdle;
      res_full_q <= 1'b0;
      idx_q <= '0;
    end else begin
      unique case (st_q)
        StIdle: begin
          // a result only waits while idle
          if (pop_i && res_full_q) res_full_q <= 1'b0;
          if (start) st_q <= StDone;
        end
        StDone: begin
          st_q <= scan_go ? StScan : StIdle;
          res_full_q <= !scan_go;
          idx_q <= '0;
          priority case (cur_q.kind)
            KindAdd: if (free_any) begin
              valid_q[free_idx] <= 1'b1;
              next_id_q <= next_id_q + 32'd1;
              count_q <= count_q + CW'(1);
            end
            KindRemove: if (id_any) begin
              valid_q[id_idx] <= 1'b0;
              count_q <= count_q - CW'(1);
            end
            default: ;
          endcase
        end
        StScan: begin
          if ((match && pass && !is_log) || last) begin
            st_q <= StIdle;
            res_full_q <= 1'b1;
          end
          idx_q <= idx_q + SW'(1);
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) cur_q <= cmd_i;
    if (st_q == StDone) begin
      res_q <= done_res;
      priority case (cur_q.kind)
        KindAdd: if (free_any) begin
          ident_q[free_idx] <= next_id_q;
          script_q[free_idx] <= cur_q.script_id;
          line_q[free_idx] <= cur_q.line_number;
          en_q[free_idx] <= 1'b1;
          cond_q[free_idx] <= 1'b0;
          logp_q[free_idx] <= 1'b0;
          msg_q[free_idx] <= 1'b0;
          hits_q[free_idx] <= '0;
        end
        KindEnable: if (id_any) en_q[id_idx] <= cur_q.flag;
        KindCond: if (id_any) cond_q[id_idx] <= cur_q.flag;
        KindLog: if (id_any) begin
          logp_q[id_idx] <= 1'b1;
          msg_q[id_idx] <= cur_q.flag;
        end
        default: ;
      endcase
    end
    if (st_q == StScan && match) begin
      if (hits_q[idx_q] != '1) hits_q[idx_q] <= hits_q[idx_q] + 32'd1;
      if (pass) begin
        if (!is_log) res_q.pause <= 1'b1;
        else if (msg_q[idx_q] && 32'(idx_q) < 16) res_q.log_mask[4'(idx_q)] <= 1'b1;
      end
    end
  end

  assign empty_o = !res_full_q;
  assign pause_o = res_q.pause;
  assign ok_o = res_q.ok;
  assign assigned_id_o = res_q.assigned_id;
  assign log_mask_o = res_q.log_mask;
  assign active_count_o = (32'(count_q) > 31) ? 5'd31 : 5'(count_q);

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take_o |-> (st_q == StIdle && !res_full_q)) else $error("take while busy");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'($countones(valid_q)) == 32'(count_q)) else $error("count mismatch");
  a_scan_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StScan) |-> !res_full_q) else $error("result during scan");
endmodule
`default_nettype wire

@@ test/tb_breakpoint_and_step_matcher.sv @@
// Testbench for breakpoint_and_step_matcher: directed and random commands
// checked against a breakpoint table predictor. Depends on bsm_pkg.
module tb_breakpoint_and_step_matcher;
  import bsm_pkg::*;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] script_id;
    logic [31:0] line_number;
    logic [15:0] call_depth;
    logic [31:0] bp_id;
    logic        flag;
    logic [15:0] cmask;
    logic [2:0]  action;
  } cmd_item_t;

  typedef struct {
    logic        pause;
    logic        ok;
    logic [31:0] assigned_id;
    logic [15:0] log_mask;
    logic [4:0]  active_count;
  } bp_result_t;

  class bp_table_board;
    bit          valid [16];
    bit [31:0]   ident [16];
    bit [31:0]   script [16];
    bit [31:0]   line [16];
    bit          enabled [16];
    bit          conditional [16];
    bit          logpoint [16];
    bit          has_msg [16];
    bit [31:0]   hits [16];
    bit [31:0]   next_ident = 1;
    bit [2:0]    step_mode = StepCont;
    bit [15:0]   step_depth = 0;
    bit          debug_en = 0;
    bit          cond_ev = 0;
    bp_result_t  expected_q[$];
    int          errors = 0;

    function int find_slot(bit [31:0] id);
      for (int s = 0; s < 16; s++) if (valid[s] && ident[s] == id) return s;
      return -1;
    endfunction

    function bit [31:0] pick_id();
      bit [31:0] ids[$];
      for (int s = 0; s < 16; s++) if (valid[s]) ids.push_back(ident[s]);
      if (ids.size() == 0 || $urandom_range(99) < 15) return $urandom;
      return ids[$urandom_range(ids.size() - 1)];
    endfunction

    // compute the expected outcome of an accepted command and update the table
    function void note_cmd(cmd_item_t c);
      bp_result_t r;
      int s;
      int n;
      r = '{default: '0};
      case (c.kind)
        KindAdd: begin
          s = -1;
          for (int i = 15; i >= 0; i--) if (!valid[i]) s = i;
          if (s >= 0) begin
            valid[s] = 1; ident[s] = next_ident; script[s] = c.script_id;
            line[s] = c.line_number; enabled[s] = 1; conditional[s] = 0;
            logpoint[s] = 0; has_msg[s] = 0; hits[s] = 0;
            r.assigned_id = next_ident;
            next_ident++;
            r.ok = 1;
          end
        end
        KindRemove, KindEnable, KindCond, KindLog: begin
          s = find_slot(c.bp_id);
          if (s >= 0) begin
            r.ok = 1;
            case (c.kind)
              KindRemove: valid[s] = 0;
              KindEnable: enabled[s] = c.flag;
              KindCond:   conditional[s] = c.flag;
              default: begin
                logpoint[s] = 1;
                has_msg[s] = c.flag;
              end
            endcase
          end
        end
        KindCheck: if (debug_en) begin
          if (step_mode == StepInto ||
              (step_mode == StepOver && c.call_depth <= step_depth) ||
              (step_mode == StepOut && c.call_depth < step_depth)) begin
            r.pause = 1;
          end else begin
            for (int i = 0; i < 16; i++) begin
              if (!valid[i] || !enabled[i] || script[i] != c.script_id ||
                  line[i] != c.line_number) continue;
              if (hits[i] != 32'hFFFF_FFFF) hits[i]++;
              if (conditional[i] && cond_ev && !c.cmask[i]) continue;
              if (logpoint[i]) begin
                if (has_msg[i]) r.log_mask[i] = 1;
                continue;
              end
              r.pause = 1;
              break;
            end
          end
        end
        KindResume: begin
          step_mode = (c.action <= StepPause) ? c.action : StepCont;
          step_depth = c.call_depth;
          r.ok = 1;
        end
        default: ;
      endcase
      n = 0;
      for (int i = 0; i < 16; i++) n += valid[i];
      r.active_count = 5'((n > 31) ? 31 : n);
      expected_q.push_back(r);
    endfunction

    function void check_result(bp_result_t a);
      bp_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected", $time);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (a.pause !== e.pause) begin
        $display("%0t: pause exp %0h got %0h", $time, e.pause, a.pause); errors++;
      end
      if (a.ok !== e.ok) begin
        $display("%0t: ok exp %0h got %0h", $time, e.ok, a.ok); errors++;
      end
      if (a.assigned_id !== e.assigned_id) begin
        $display("%0t: assigned_id exp %0h got %0h", $time, e.assigned_id,
                 a.assigned_id);
        errors++;
      end
      if (a.log_mask !== e.log_mask) begin
        $display("%0t: log_mask exp %0h got %0h", $time, e.log_mask, a.log_mask);
        errors++;
      end
      if (a.active_count !== e.active_count) begin
        $display("%0t: active_count exp %0d got %0d", $time, e.active_count,
                 a.active_count);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        push = 0;
  logic        full;
  logic [2:0]  kind_i = '0;
  logic [31:0] script_id_i = '0;
  logic [31:0] line_number_i = '0;
  logic [15:0] call_depth_i = '0;
  logic [31:0] bp_id_i = '0;
  logic        flag_i = 0;
  logic [15:0] condition_pass_mask_i = '0;
  logic [2:0]  action_i = '0;
  logic        empty;
  logic        pop = 0;
  logic        pause_o, ok_o;
  logic [31:0] assigned_id_o;
  logic [15:0] log_mask_o;
  logic [4:0]  active_count_o;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bp_table_board board = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;

  breakpoint_and_step_matcher u_dut (.*);

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  // result side: check on transfer, then choose pop for the next edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty)
        board.check_result('{pause_o, ok_o, assigned_id_o, log_mask_o,
                             active_count_o});
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 3000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_cmd(cmd_item_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 0;
      @(posedge clk_i);
    end
    push <= 1;
    kind_i <= c.kind; script_id_i <= c.script_id; line_number_i <= c.line_number;
    call_depth_i <= c.call_depth; bp_id_i <= c.bp_id; flag_i <= c.flag;
    condition_pass_mask_i <= c.cmask; action_i <= c.action;
    do @(posedge clk_i); while (full);
    board.note_cmd(c);
  endtask

  task automatic drain();
    push <= 0;
    while (board.expected_q.size() > 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] value);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (idx == RegDebugEn) board.debug_en = value[0];
    else board.cond_ev = value[0];
  endtask

  function automatic cmd_item_t mk(logic [2:0] k, logic [31:0] sc, logic [31:0] ln,
                                   logic [15:0] d, logic [31:0] id, logic f,
                                   logic [15:0] m, logic [2:0] a);
    cmd_item_t c;
    c = '{k, sc, ln, d, id, f, m, a};
    return c;
  endfunction

  function automatic logic [31:0] pool_value();
    case ($urandom_range(4))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return 32'd7;
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_item_t rand_cmd();
    cmd_item_t c;
    int r;
    c = mk(3'($urandom), $urandom, $urandom, 16'($urandom), $urandom, 1'($urandom),
           16'($urandom), 3'($urandom));
    if ($urandom_range(99) < 5) return c;  // raw noise
    c.script_id = pool_value();
    c.line_number = pool_value();
    c.call_depth = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(6));
    c.bp_id = board.pick_id();
    r = $urandom_range(99);
    if (r < 20) c.kind = KindAdd;
    else if (r < 30) c.kind = KindRemove;
    else if (r < 38) c.kind = KindEnable;
    else if (r < 46) c.kind = KindCond;
    else if (r < 54) c.kind = KindLog;
    else if (r < 90) c.kind = KindCheck;
    else if (r < 98) c.kind = KindResume;
    else c.kind = 3'd7;
    // mostly resume to continue so the scan is reached
    if (c.kind == KindResume && $urandom_range(1)) c.action = StepCont;
    return c;
  endfunction

  initial begin
    bit [1:0] cfg;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    write_reg(RegDebugEn, 1);
    write_reg(RegCondEv, 1);

    send_cmd(mk(KindAdd, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
    send_cmd(mk(KindAdd, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(KindAdd, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(KindAdd, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(KindCond, 0, 0, 0, 2, 1, 0, 0));
    send_cmd(mk(KindLog, 0, 0, 0, 3, 1, 0, 0));
    send_cmd(mk(KindLog, 0, 0, 0, 4, 0, 0, 0));
    send_cmd(mk(KindCheck, 0, 0, 0, 0, 0, 16'h0000, 0));
    send_cmd(mk(KindCheck, 0, 0, 0, 0, 0, 16'hFFFF, 0));
    send_cmd(mk(KindEnable, 0, 0, 0, 2, 0, 0, 0));
    send_cmd(mk(KindCheck, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 0, 0, 0, 0));
    send_cmd(mk(KindRemove, 0, 0, 0, 32'hFFFF_FFFF, 1, 0, 0));
    send_cmd(mk(KindResume, 0, 0, 5, 0, 0, 0, StepInto));
    send_cmd(mk(KindCheck, 9, 9, 9, 0, 0, 0, 0));
    send_cmd(mk(KindResume, 0, 0, 5, 0, 0, 0, StepOver));
    send_cmd(mk(KindCheck, 9, 9, 5, 0, 0, 0, 0));
    send_cmd(mk(KindCheck, 9, 9, 6, 0, 0, 0, 0));
    send_cmd(mk(KindResume, 0, 0, 5, 0, 0, 0, StepOut));
    send_cmd(mk(KindCheck, 9, 9, 5, 0, 0, 0, 0));
    send_cmd(mk(KindCheck, 9, 9, 4, 0, 0, 0, 0));
    send_cmd(mk(KindResume, 0, 0, 16'hFFFF, 0, 0, 0, 3'd7));
    send_cmd(mk(3'd7, '1, '1, '1, '1, 1, '1, '1));
    send_cmd(mk(KindRemove, 0, 0, 0, 1, 0, 0, 0));
    send_cmd(mk(KindCheck, 0, 0, 0, 0, 0, 0, 0));
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p / 2)
        0: begin send_idle_pct = 37; recv_idle_pct = 46; end
        1: begin send_idle_pct = 46; recv_idle_pct = 37; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      cfg = (p == 5) ? 2'b11 : 2'(p + 1);
      write_reg(RegDebugEn, cfg[0]);
      write_reg(RegCondEv, cfg[1]);
      for (int i = 0; i < 320; i++) begin
        // a single full pause of the sender, in the second pass, until the block is idle
        if (i == 160 && p == 1) drain();
        send_cmd(rand_cmd());
      end
      drain();
    end

    if (board.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

@@ sim.f @@
rtl/bsm_pkg.sv
rtl/bsm_front.sv
rtl/bsm_back.sv
rtl/breakpoint_and_step_matcher.sv
test/tb_breakpoint_and_step_matcher.sv
